>>> src/rsfe_pkg.sv
// Package for the simplest-radical-form extractor.
// Holds the shared widths and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rsfe_pkg;

    localparam int VALUE_BITS_DEF = 24;
    localparam int OUT_W          = 12;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
        logic advance;
        logic out_load;
    } t_dp_cmd;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic sq_gt_rest;
        logic rem_zero;
    } t_dp_status;

endpackage

`default_nettype wire

>>> src/rsfe_datapath.sv
// Datapath of the simplest-radical-form extractor: value, coefficient, trial divisor,
// its square, a radix-4 restoring divider and the result registers. Uses rsfe_pkg.
`default_nettype none

module rsfe_datapath #(
    parameter int VALUE_BITS = rsfe_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic [VALUE_BITS-2:0]       i_radicand,
    input  wire rsfe_pkg::t_dp_cmd           i_cmd,
    output rsfe_pkg::t_dp_status             o_status,
    output logic      [rsfe_pkg::OUT_W-1:0]  o_outside_factor,
    output logic      [VALUE_BITS-2:0]       o_inside_factor
);
    import rsfe_pkg::*;

    localparam int RAD_W     = VALUE_BITS - 1;
    localparam int SQ_W      = VALUE_BITS;
    localparam int TRIAL_W   = VALUE_BITS / 2 + 1;
    localparam int DIV_ITERS = VALUE_BITS / 2;
    localparam int DIV_W     = 2 * DIV_ITERS;

    logic [RAD_W-1:0]   r_rest, n_rest;
    logic [OUT_W-1:0]   r_coef, n_coef;
    logic [TRIAL_W-1:0] r_trial, n_trial;
    logic [SQ_W-1:0]    r_sq, n_sq;
    logic [DIV_W-1:0]   r_quo, n_quo;
    logic [SQ_W-1:0]    r_rem, n_rem;
    logic [OUT_W-1:0]   r_out_outside;
    logic [RAD_W-1:0]   r_out_inside;

    logic [SQ_W:0]      part;
    logic [SQ_W-1:0]    rem_v;
    logic [DIV_W-1:0]   quo_v;
    logic [OUT_W-1:0]   trial_lo;

    // Two restoring quotient bits per cycle while div_step is asserted.
    always_comb begin
        part  = '0;
        rem_v = r_rem;
        quo_v = r_quo;
        for (int k = 0; k < 2; k++) begin
            part  = {rem_v, quo_v[DIV_W-1]};
            quo_v = {quo_v[DIV_W-2:0], 1'b0};
            if (part >= {1'b0, r_sq}) begin
                part     = part - {1'b0, r_sq};
                quo_v[0] = 1'b1;
            end
            rem_v = part[SQ_W-1:0];
        end
    end

    assign trial_lo = OUT_W'(r_trial);

    always_comb begin
        n_rest  = r_rest;
        n_coef  = r_coef;
        n_trial = r_trial;
        n_sq    = r_sq;
        n_quo   = r_quo;
        n_rem   = r_rem;
        if (i_cmd.load) begin
            n_rest  = i_radicand;
            n_coef  = OUT_W'(1);
            n_trial = TRIAL_W'(2);
            n_sq    = SQ_W'(4);
        end
        if (i_cmd.div_start) begin
            n_quo = DIV_W'(r_rest);
            n_rem = '0;
        end
        if (i_cmd.div_step) begin
            n_quo = quo_v;
            n_rem = rem_v;
        end
        if (i_cmd.update) begin
            // The square divided evenly: keep the same trial divisor for repeats.
            n_rest = RAD_W'(r_quo);
            n_coef = OUT_W'(r_coef * trial_lo);
        end
        if (i_cmd.advance) begin
            // (d+1)^2 = d^2 + 2d + 1
            n_trial = r_trial + TRIAL_W'(1);
            n_sq    = r_sq + SQ_W'({r_trial, 1'b1});
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_coef  <= n_coef;
        r_trial <= n_trial;
        r_sq    <= n_sq;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        if (i_cmd.out_load) begin
            r_out_outside <= r_coef;
            r_out_inside  <= r_rest;
        end
    end

    assign o_status.sq_gt_rest = (r_sq > SQ_W'(r_rest));
    assign o_status.rem_zero   = (r_rem == '0);
    assign o_outside_factor    = r_out_outside;
    assign o_inside_factor     = r_out_inside;

endmodule

`default_nettype wire

>>> src/rsfe_ctrl.sv
// Controller of the simplest-radical-form extractor: sequences trial divisions and
// owns the input and output handshakes. Uses rsfe_pkg.
`default_nettype none

module rsfe_ctrl #(
    parameter int VALUE_BITS = rsfe_pkg::VALUE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rsfe_pkg::t_dp_cmd         o_cmd,
    input  wire rsfe_pkg::t_dp_status i_status
);
    import rsfe_pkg::*;

    localparam int DIV_ITERS = VALUE_BITS / 2;
    localparam int CNT_W     = $clog2(DIV_ITERS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.sq_gt_rest) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = CNT_W'(DIV_ITERS - 1);
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.rem_zero) begin
                    o_cmd.update = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                end
                n_state = ST_CHECK;
            end
            ST_DONE: begin
                // Wait here only while the previous result is still held.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> src/radical_square_factor_extract.sv
// Simplest radical form: sqrt(n) = outside_factor * sqrt(inside_factor).
//
// Input channel: i_valid / o_stall carry i_radicand; a transaction completes on a
// rising edge with i_valid high and o_stall low. Output channel: o_valid / i_stall
// carry o_outside_factor and o_inside_factor, one result per input.
//
// Each trial divisor d is handled in order: compare d*d with the value, run the divider,
// which retires two quotient bits per cycle, and apply the result. Divisors are tried
// up to the root of what remains, and a divisor is tried again after each square
// factor it removes. Inputs 0 to 3 go from the first compare straight to the result.
//
// One item is worked on at a time; o_stall stays high from acceptance until the
// result is moved into the output register. A finished result waits there while
// i_stall is high, and the next item can be accepted meanwhile; its own result then
// waits in the datapath registers until the output register is free.
// Synchronous active-low reset returns the controller to idle and drops o_valid.
// Depends on rsfe_pkg, rsfe_ctrl and rsfe_datapath.
`default_nettype none

module radical_square_factor_extract #(
    parameter int VALUE_BITS = rsfe_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [VALUE_BITS-2:0]       i_radicand,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [rsfe_pkg::OUT_W-1:0]  o_outside_factor,
    output logic      [VALUE_BITS-2:0]       o_inside_factor
);
    import rsfe_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    rsfe_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    rsfe_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_radicand       (i_radicand),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_outside_factor (o_outside_factor),
        .o_inside_factor  (o_inside_factor)
    );

    // An accepted transaction keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block ready right after accepting a transaction");

    // Only a zero input leaves zero under the root, and then nothing was extracted.
    a_zero_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_inside_factor != '0 || o_outside_factor == OUT_W'(1)))
        else $error("zero remainder with a nontrivial coefficient");

    // Reset leaves the block idle with no pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not idle after reset");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for radical_square_factor_extract: directed rows, then random radicands.
// Depends on rsfe_pkg and the block; results are predicted by a local trial-division model.
`timescale 1ns / 1ps

module testbench;
    import rsfe_pkg::*;

    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int RAD_W      = VALUE_BITS - 1;
    localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};
    localparam int RANDOM_ITEMS = 80;
    localparam int NUM_DIRECTED = 20;

    typedef struct packed {
        logic [OUT_W-1:0] outside_factor;
        logic [RAD_W-1:0] inside_factor;
    } radical_form_t;

    typedef struct packed {
        logic [RAD_W-1:0] radicand;
        logic             typed;
        radical_form_t    form;
    } directed_row_t;

    // Rows with typed set carry a result that can be read off directly.
    localparam directed_row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
        '{23'd0,       1'b1, '{12'd1,    23'd0}},
        '{23'd1,       1'b1, '{12'd1,    23'd1}},
        '{23'd2,       1'b1, '{12'd1,    23'd2}},
        '{23'd3,       1'b1, '{12'd1,    23'd3}},
        '{23'd4,       1'b1, '{12'd2,    23'd1}},
        '{23'd6,       1'b1, '{12'd1,    23'd6}},
        '{23'd8,       1'b1, '{12'd2,    23'd2}},
        '{23'd9,       1'b1, '{12'd3,    23'd1}},
        '{23'd16,      1'b1, '{12'd4,    23'd1}},
        '{23'd18,      1'b1, '{12'd3,    23'd2}},
        '{23'd48,      1'b0, '{12'd0,    23'd0}},
        '{23'd72,      1'b0, '{12'd0,    23'd0}},
        '{23'd97,      1'b0, '{12'd0,    23'd0}},
        '{23'd1000000, 1'b1, '{12'd1000, 23'd1}},
        '{23'd4194304, 1'b1, '{12'd2048, 23'd1}},
        '{23'd8386816, 1'b1, '{12'd2896, 23'd1}},
        '{23'd8334769, 1'b0, '{12'd0,    23'd0}},
        '{23'h555555,  1'b0, '{12'd0,    23'd0}},
        '{23'h2AAAAA,  1'b0, '{12'd0,    23'd0}},
        '{23'h7FFFFF,  1'b0, '{12'd0,    23'd0}}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [RAD_W-1:0]   i_radicand;
    logic               o_valid;
    logic               i_stall;
    logic [OUT_W-1:0]   o_outside_factor;
    logic [RAD_W-1:0]   o_inside_factor;

    radical_form_t      pending_forms[$];
    int                 error_count;

    radical_square_factor_extract #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_radicand       (i_radicand),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_outside_factor (o_outside_factor),
        .o_inside_factor  (o_inside_factor)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Pull out square factors by trial division, keeping the divisor for repeats.
    function automatic radical_form_t simplify_radical(input logic [RAD_W-1:0] value);
        radical_form_t   form;
        longint unsigned rest;
        longint unsigned coef;
        longint unsigned trial;
        rest  = 64'(value);
        coef  = 1;
        trial = 2;
        while (trial * trial <= rest) begin
            if (rest % (trial * trial) == 0) begin
                rest = rest / (trial * trial);
                coef = coef * trial;
            end else begin
                trial++;
            end
        end
        form.outside_factor = coef[OUT_W-1:0];
        form.inside_factor  = rest[RAD_W-1:0];
        return form;
    endfunction

    // Mostly small values; large ones are built from small primes so the divisor
    // search stays short, and only a few are fully random across the range.
    function automatic logic [RAD_W-1:0] pick_radicand();
        int unsigned     kind;
        longint unsigned root;
        longint unsigned base;
        longint unsigned prime;
        int unsigned     primes [6];
        kind   = $urandom_range(0, 99);
        primes = '{2, 3, 5, 7, 11, 13};
        if (kind < 5) begin
            return RAD_W'($urandom);
        end
        if (kind < 15) begin
            return RAD_W'($urandom_range(0, 3));
        end
        if (kind < 65) begin
            return RAD_W'($urandom_range(0, 4095));
        end
        base = 64'($urandom_range(1, 15));
        root = 1;
        for (int i = 0; i < 24; i++) begin
            prime = 64'(primes[$urandom_range(0, 5)]);
            if ((root * prime) * (root * prime) * base > RAD_MAX || $urandom_range(0, 7) == 0) begin
                break;
            end
            root = root * prime;
        end
        return RAD_W'(root * root * base);
    endfunction

    task automatic send_radicand(input logic [RAD_W-1:0] value, input radical_form_t form);
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_radicand = value;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_forms.push_back(form);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid    = 1'b0;
            i_radicand = RAD_W'($urandom);
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        while (pending_forms.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned kind;
        kind = $urandom_range(0, 19);
        if (kind < 8) begin
            return 0;
        end
        if (kind < 18) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result side: quiet stretches alternate with stalls, mostly short and a few long.
    initial begin
        int unsigned quiet;
        int unsigned hold;
        i_stall = 1'b0;
        forever begin
            quiet = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 6);
            repeat (quiet) begin
                @(negedge i_clk);
                i_stall = 1'b0;
            end
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            repeat (hold) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        radical_form_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_forms.size() == 0) begin
                $display("%0t: unexpected result outside=%0d inside=%0d",
                         $time, o_outside_factor, o_inside_factor);
                error_count++;
            end else begin
                want = pending_forms.pop_front();
                if (o_outside_factor !== want.outside_factor) begin
                    $display("%0t: outside_factor expected %0d, got %0d",
                             $time, want.outside_factor, o_outside_factor);
                    error_count++;
                end
                if (o_inside_factor !== want.inside_factor) begin
                    $display("%0t: inside_factor expected %0d, got %0d",
                             $time, want.inside_factor, o_inside_factor);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [RAD_W-1:0] value;
        radical_form_t    form;
        error_count = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_radicand  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int row = 0; row < NUM_DIRECTED; row++) begin
            value = DIRECTED_ROWS[row].radicand;
            form  = DIRECTED_ROWS[row].typed ? DIRECTED_ROWS[row].form : simplify_radical(value);
            send_radicand(value, form);
            idle_sender(pick_gap());
        end

        idle_sender(1);
        drain_results();

        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            value = pick_radicand();
            send_radicand(value, simplify_radical(value));
            if (item == RANDOM_ITEMS / 2) begin
                idle_sender(1);
                drain_results();
            end
            idle_sender(pick_gap());
        end

        idle_sender(1);
        drain_results();
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Far beyond the slowest legal run, even with every item at its worst case.
    initial begin
        #400_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
